// ===== design/gtws_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gtws_pkg;

  // Sizing of the stores
  localparam int MAX_SPS      = 2048;
  localparam int MAX_SYMBOLS  = 128;
  localparam int SINE_ENTRIES = 1024;
  localparam int MAX_RAMP     = 256;
  localparam int PULSE_DEPTH  = 3 * MAX_SPS;

  localparam int SYM_AW   = $clog2(MAX_SYMBOLS);
  localparam int PULSE_AW = $clog2(PULSE_DEPTH);
  localparam int SINE_AW  = $clog2(SINE_ENTRIES);
  localparam int RAMP_AW  = $clog2(MAX_RAMP);

  // Field widths
  localparam int ACT_W    = 2;
  localparam int TSEL_W   = 2;
  localparam int IDX_W    = 13;
  localparam int VAL_W    = 16;
  localparam int SMP_W    = 16;
  localparam int TONE_W   = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;
  localparam int SPS_W    = 12;
  localparam int NSYM_W   = 8;
  localparam int RLEN_W   = 9;
  localparam int PHASE_W  = 32;

  // Position and waveform counters
  localparam int P_W   = SYM_AW;
  localparam int Q_W   = $clog2(MAX_SPS);
  localparam int K_W   = P_W + Q_W;
  localparam int NW_W  = K_W + 1;
  localparam int ACC_W = TONE_W + VAL_W + 2;

  // Shared multiplier
  localparam int MUL_A_W = PHASE_W + 1;
  localparam int MUL_B_W = ACC_W + 1;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int FRAC_W  = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SPS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NSYM    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CARRIER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEV     = 3'd4;

  // Table selects
  localparam logic [TSEL_W-1:0] TBL_PULSE = 2'd0;
  localparam logic [TSEL_W-1:0] TBL_RAMP  = 2'd1;
  localparam logic [TSEL_W-1:0] TBL_SINE  = 2'd2;

  typedef enum logic [ACT_W-1:0] {
    ACT_TABLE,
    ACT_SYMBOL,
    ACT_START,
    ACT_TICK
  } gtws_action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POS,
    ST_K,
    ST_NW,
    ST_W1,
    ST_W2,
    ST_W3,
    ST_DEV,
    ST_RS,
    ST_RE,
    ST_OUT
  } gtws_state_t;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_K,
    MUL_NW,
    MUL_NEXT,
    MUL_CUR,
    MUL_PREV,
    MUL_RS,
    MUL_DEV,
    MUL_RE
  } gtws_mul_op_t;

  typedef struct packed {
    logic [P_W-1:0]          p_cl;
    logic [NSYM_W-1:0]       n_sym;
    logic [SPS_W-1:0]        n_sps;
    logic [TONE_W-1:0]       sym_a;
    logic [TONE_W-1:0]       sym_b;
    logic [VAL_W-1:0]        pulse;
    logic [PHASE_W-1:0]      dev;
    logic [ACC_W-1:0]        acc;
    logic [SMP_W-1:0]        sine;
    logic [SMP_W-1:0]        s1;
    logic [VAL_W-1:0]        ramp;
  } gtws_mul_src_t;

  typedef struct packed {
    logic                    en;
    logic [ACT_W-1:0]        action;
    logic [TSEL_W-1:0]       table_select;
    logic [IDX_W-1:0]        index;
    logic [VAL_W-1:0]        value;
  } gtws_wr_t;

  typedef struct packed {
    logic                    sym_a_en;
    logic [SYM_AW-1:0]       sym_a_addr;
    logic                    sym_b_en;
    logic [SYM_AW-1:0]       sym_b_addr;
    logic                    pulse_en;
    logic [PULSE_AW-1:0]     pulse_addr;
    logic                    sine_en;
    logic [SINE_AW-1:0]      sine_addr;
    logic                    ramp_en;
    logic [RAMP_AW-1:0]      ramp_addr;
  } gtws_rd_t;

endpackage

`default_nettype wire

// ===== design/gtws_intf.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface gtws_item_if import gtws_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [TSEL_W-1:0] table_select;
  logic [IDX_W-1:0]  index;
  logic [VAL_W-1:0]  value;

  modport source (output valid, action, table_select, index, value, input ready);
  modport sink   (input valid, action, table_select, index, value, output ready);
endinterface

interface gtws_result_if import gtws_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] sample;
  logic                    last;

  modport source (output valid, sample, last, input ready);
  modport sink   (input valid, sample, last, output ready);
endinterface

interface gtws_cfg_if import gtws_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/gtws_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gtws_mem import gtws_pkg::*; (
  input  logic              clk,
  input  gtws_wr_t          wr,
  input  gtws_rd_t          rd,
  output logic [TONE_W-1:0] sym_a,
  output logic [TONE_W-1:0] sym_b,
  output logic [VAL_W-1:0]  pulse,
  output logic [VAL_W-1:0]  sine,
  output logic [VAL_W-1:0]  ramp
);

  logic [TONE_W-1:0] sym_mem   [MAX_SYMBOLS];
  logic [VAL_W-1:0]  pulse_mem [PULSE_DEPTH];
  logic [VAL_W-1:0]  ramp_mem  [MAX_RAMP];
  logic [VAL_W-1:0]  sine_mem  [SINE_ENTRIES];

  logic tbl_wr;
  logic sym_wr;

  assign tbl_wr = wr.en && (wr.action == ACT_TABLE);
  assign sym_wr = wr.en && (wr.action == ACT_SYMBOL);

  // Symbol store: one write port, two read ports
  always_ff @(posedge clk) begin
    if (sym_wr && (32'(wr.index) < MAX_SYMBOLS)) begin
      sym_mem[wr.index[SYM_AW-1:0]] <= wr.value[TONE_W-1:0];
    end
    if (rd.sym_a_en) begin
      sym_a <= sym_mem[rd.sym_a_addr];
    end
    if (rd.sym_b_en) begin
      sym_b <= sym_mem[rd.sym_b_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_wr && (wr.table_select == TBL_PULSE) && (32'(wr.index) < PULSE_DEPTH)) begin
      pulse_mem[wr.index[PULSE_AW-1:0]] <= wr.value;
    end
    if (rd.pulse_en) begin
      pulse <= pulse_mem[rd.pulse_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_wr && (wr.table_select == TBL_RAMP) && (32'(wr.index) < MAX_RAMP)) begin
      ramp_mem[wr.index[RAMP_AW-1:0]] <= wr.value;
    end
    if (rd.ramp_en) begin
      ramp <= ramp_mem[rd.ramp_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_wr && (wr.table_select == TBL_SINE) && (32'(wr.index) < SINE_ENTRIES)) begin
      sine_mem[wr.index[SINE_AW-1:0]] <= wr.value;
    end
    if (rd.sine_en) begin
      sine <= sine_mem[rd.sine_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/gtws_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gtws_mul import gtws_pkg::*; (
  input  logic                      clk,
  input  gtws_mul_op_t              op,
  input  gtws_mul_src_t             src,
  output logic signed [MUL_P_W-1:0] prod
);

  logic signed [MUL_A_W-1:0] a;
  logic signed [MUL_B_W-1:0] b;

  // operand select; unsigned values zero-extend, samples sign-extend
  always_comb begin
    unique case (op)
      MUL_K: begin
        a = MUL_A_W'(src.p_cl);
        b = MUL_B_W'(src.n_sps);
      end
      MUL_NW: begin
        a = MUL_A_W'(src.n_sym);
        b = MUL_B_W'(src.n_sps);
      end
      MUL_NEXT, MUL_PREV: begin
        a = MUL_A_W'(src.sym_a);
        b = MUL_B_W'(src.pulse);
      end
      MUL_CUR: begin
        a = MUL_A_W'(src.sym_b);
        b = MUL_B_W'(src.pulse);
      end
      MUL_RS: begin
        a = {{(MUL_A_W-SMP_W){src.sine[SMP_W-1]}}, src.sine};
        b = MUL_B_W'(src.ramp);
      end
      MUL_DEV: begin
        a = MUL_A_W'(src.dev);
        b = MUL_B_W'(src.acc);
      end
      MUL_RE: begin
        a = {{(MUL_A_W-SMP_W){src.s1[SMP_W-1]}}, src.s1};
        b = MUL_B_W'(src.ramp);
      end
      default: begin
        a = '0;
        b = '0;
      end
    endcase
  end

  // product holds while idle
  always_ff @(posedge clk) begin
    if (op != MUL_NONE) begin
      prod <= a * b;
    end
  end

endmodule

`default_nettype wire

// ===== design/gfsk_tone_waveform_synth.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Dir | Fields                                   | Beat when
// ---------+-----+------------------------------------------+-------------------------
// item     | in  | action, table_select, index, value       | item.valid & item.ready
// result   | out | sample (signed Q1.15), last              | result.valid & result.ready
// cfg      | in  | index (register number), data            | cfg.valid & cfg.ready
//
// Table writes, symbol writes and start take effect when accepted; a tick while
// idle is dropped. A tick while running passes through ten sequencer steps
// around the one shared multiplier, which does the position product, the
// waveform length, three pulse products, two ramp products and the deviation
// product in turn.
// rst is synchronous, active high; it restores the register defaults and
// leaves the waveform idle. Table contents are not cleared.
// A result waits in the output register; only the next sample stalls behind
// it. cfg is always ready.

module gfsk_tone_waveform_synth import gtws_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  gtws_item_if.sink     item,
  gtws_result_if.source result,
  gtws_cfg_if.sink      cfg
);

  // configuration registers
  logic [SPS_W-1:0]   sps;
  logic [NSYM_W-1:0]  nsym;
  logic [RLEN_W-1:0]  ramp_len;
  logic [PHASE_W-1:0] carrier;
  logic [PHASE_W-1:0] dev_step;

  // waveform state
  gtws_state_t        state;
  gtws_state_t        state_next;
  logic [PHASE_W-1:0] phase;
  logic [P_W-1:0]     pos_p;
  logic [Q_W-1:0]     pos_q;
  logic               running;

  // per-sample working registers
  logic [P_W-1:0]          pc;
  logic [Q_W-1:0]          qc;
  logic                    last_c;
  logic [K_W-1:0]          k;
  logic [NW_W-1:0]         nw;
  logic [ACC_W-1:0]        acc;
  logic signed [SMP_W-1:0] s1;

  // output register
  logic                    out_valid;
  logic signed [SMP_W-1:0] out_sample;
  logic                    out_last;

  // clamped registers and position
  logic [SPS_W-1:0]  n_sps;
  logic [NSYM_W-1:0] n_sym;
  logic [RLEN_W-1:0] r_len;
  logic [P_W-1:0]    p_last;
  logic [Q_W-1:0]    q_last;
  logic              past_end;
  logic [P_W-1:0]    p_cl;
  logic [Q_W-1:0]    q_cl;
  logic              last_now;
  logic [NSYM_W-1:0] p_inc;
  logic [P_W-1:0]    p_next_sym;
  logic [P_W-1:0]    p_prev_sym;
  logic [NW_W-1:0]   e_off;
  logic              ramp_s_on;
  logic              ramp_e_on;
  logic [SPS_W-1:0]  q_inc;

  // memory and multiplier hookup
  gtws_wr_t                  wr;
  gtws_rd_t                  rd;
  logic [TONE_W-1:0]         sym_a;
  logic [TONE_W-1:0]         sym_b;
  logic [VAL_W-1:0]          pulse;
  logic [VAL_W-1:0]          sine;
  logic [VAL_W-1:0]          ramp;
  gtws_mul_op_t              mul_op;
  gtws_mul_src_t             mul_src;
  logic signed [MUL_P_W-1:0] prod;

  logic                    item_acc;
  logic                    out_load;
  logic [PHASE_W-1:0]      dev_rnd;
  logic signed [SMP_W-1:0] ramp_prod;
  logic signed [SMP_W-1:0] s2;

  // (x + 1/2) >> 16 on the product, floor toward -inf: half rounds up
  function automatic logic signed [SMP_W-1:0] ramp_round(
    input logic signed [MUL_P_W-1:0] x
  );
    logic signed [MUL_P_W-1:0] r;
    r = x + MUL_P_W'(1 << (FRAC_W - 1));
    return r[FRAC_W+SMP_W-1:FRAC_W];
  endfunction

  assign item_acc   = item.valid && item.ready;
  assign item.ready = (state == ST_IDLE);
  assign cfg.ready  = 1'b1;

  // ---------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      sps      <= SPS_W'(1920);
      nsym     <= NSYM_W'(79);
      ramp_len <= RLEN_W'(240);
      carrier  <= PHASE_W'(536870912);
      dev_step <= PHASE_W'(2236962);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_SPS:     sps      <= cfg.data[SPS_W-1:0];
        REG_NSYM:    nsym     <= cfg.data[NSYM_W-1:0];
        REG_RAMP:    ramp_len <= cfg.data[RLEN_W-1:0];
        REG_CARRIER: carrier  <= cfg.data[PHASE_W-1:0];
        REG_DEV:     dev_step <= cfg.data[PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Clamps and position
  // ---------------------------------------------------------------------
  always_comb begin
    if (sps == '0) begin
      n_sps = SPS_W'(1);
    end else if (32'(sps) > MAX_SPS) begin
      n_sps = SPS_W'(MAX_SPS);
    end else begin
      n_sps = sps;
    end
    if (nsym == '0) begin
      n_sym = NSYM_W'(1);
    end else if (32'(nsym) > MAX_SYMBOLS) begin
      n_sym = NSYM_W'(MAX_SYMBOLS);
    end else begin
      n_sym = nsym;
    end
    r_len = (32'(ramp_len) > MAX_RAMP) ? RLEN_W'(MAX_RAMP) : ramp_len;
  end

  assign p_last   = P_W'(n_sym - NSYM_W'(1));
  assign q_last   = Q_W'(n_sps - SPS_W'(1));
  // a shortened waveform snaps to its final sample
  assign past_end = (NSYM_W'(pos_p) >= n_sym) || (SPS_W'(pos_q) >= n_sps);
  assign p_cl     = past_end ? p_last : pos_p;
  assign q_cl     = past_end ? q_last : pos_q;
  assign last_now = (p_cl == p_last) && (q_cl == q_last);

  // neighbor symbols, repeated at both ends
  assign p_inc      = NSYM_W'(p_cl) + NSYM_W'(1);
  assign p_next_sym = (p_inc >= n_sym) ? p_last : P_W'(p_inc);
  assign p_prev_sym = (pc == '0) ? '0 : pc - P_W'(1);

  // distance to the waveform end
  assign e_off     = nw - NW_W'(1) - NW_W'(k);
  assign ramp_s_on = NW_W'(k) < NW_W'(r_len);
  assign ramp_e_on = e_off < NW_W'(r_len);
  assign q_inc     = SPS_W'(qc) + SPS_W'(1);

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_op     = MUL_NONE;
    rd         = '0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (item_acc && (item.action == ACT_TICK) && running) begin
          state_next = ST_POS;
        end
      end
      ST_POS: begin
        mul_op        = MUL_K;
        rd.sym_a_en   = 1'b1;
        rd.sym_a_addr = p_next_sym;
        rd.sym_b_en   = 1'b1;
        rd.sym_b_addr = p_cl;
        rd.pulse_en   = 1'b1;
        rd.pulse_addr = PULSE_AW'(q_cl);
        rd.sine_en    = 1'b1;
        rd.sine_addr  = phase[PHASE_W-1 -: SINE_AW];
        state_next    = ST_K;
      end
      ST_K: begin
        mul_op     = MUL_NW;
        state_next = ST_NW;
      end
      ST_NW: begin
        mul_op        = MUL_NEXT;
        rd.pulse_en   = 1'b1;
        rd.pulse_addr = PULSE_AW'(n_sps) + PULSE_AW'(qc);
        rd.sym_a_en   = 1'b1;
        rd.sym_a_addr = p_prev_sym;
        state_next    = ST_W1;
      end
      ST_W1: begin
        mul_op        = MUL_CUR;
        rd.pulse_en   = 1'b1;
        rd.pulse_addr = PULSE_AW'({n_sps, 1'b0}) + PULSE_AW'(qc);
        state_next    = ST_W2;
      end
      ST_W2: begin
        mul_op     = MUL_PREV;
        state_next = ST_W3;
      end
      ST_W3: begin
        rd.ramp_en   = 1'b1;
        rd.ramp_addr = k[RAMP_AW-1:0];
        state_next   = ST_DEV;
      end
      ST_DEV: begin
        mul_op       = MUL_RS;
        rd.ramp_en   = 1'b1;
        rd.ramp_addr = e_off[RAMP_AW-1:0];
        state_next   = ST_RS;
      end
      ST_RS: begin
        mul_op     = MUL_DEV;
        state_next = ST_RE;
      end
      ST_RE: begin
        mul_op     = MUL_RE;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        // wait here while the previous sample is still unclaimed
        if (!out_valid || result.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Shared multiplier and stores
  // ---------------------------------------------------------------------
  always_comb begin
    mul_src.p_cl  = p_cl;
    mul_src.n_sym = n_sym;
    mul_src.n_sps = n_sps;
    mul_src.sym_a = sym_a;
    mul_src.sym_b = sym_b;
    mul_src.pulse = pulse;
    mul_src.dev   = dev_step;
    mul_src.acc   = acc;
    mul_src.sine  = sine;
    mul_src.s1    = s1;
    mul_src.ramp  = ramp;
  end

  gtws_mul u_mul (
    .clk  (clk),
    .op   (mul_op),
    .src  (mul_src),
    .prod (prod)
  );

  assign wr.en           = item_acc &&
                           ((item.action == ACT_TABLE) || (item.action == ACT_SYMBOL));
  assign wr.action       = item.action;
  assign wr.table_select = item.table_select;
  assign wr.index        = item.index;
  assign wr.value        = item.value;

  gtws_mem u_mem (
    .clk   (clk),
    .wr    (wr),
    .rd    (rd),
    .sym_a (sym_a),
    .sym_b (sym_b),
    .pulse (pulse),
    .sine  (sine),
    .ramp  (ramp)
  );

  // ---------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------
  always_comb begin
    logic signed [MUL_P_W-1:0] r;
    r       = prod + MUL_P_W'(1 << (FRAC_W - 1));
    dev_rnd = r[FRAC_W+PHASE_W-1:FRAC_W];
  end

  assign ramp_prod = ramp_round(prod);

  always_comb begin
    s2 = ramp_e_on ? ramp_prod : s1;
    if (s2 == {1'b1, {(SMP_W-1){1'b0}}}) begin
      s2 = {1'b1, {(SMP_W-2){1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= '0;
      pos_p   <= '0;
      pos_q   <= '0;
      running <= 1'b0;
    end else begin
      if (item_acc && (item.action == ACT_START)) begin
        phase   <= '0;
        pos_p   <= '0;
        pos_q   <= '0;
        running <= 1'b1;
      end
      if (state == ST_RE) begin
        phase <= phase + carrier + dev_rnd;
      end
      if (out_load) begin
        if (last_c) begin
          running <= 1'b0;
          pos_p   <= '0;
          pos_q   <= '0;
        end else if (q_inc >= n_sps) begin
          pos_q <= '0;
          pos_p <= pc + P_W'(1);
        end else begin
          pos_q <= Q_W'(q_inc);
          pos_p <= pc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_POS: begin
        pc     <= p_cl;
        qc     <= q_cl;
        last_c <= last_now;
      end
      ST_K:  k   <= prod[K_W-1:0] + K_W'(qc);
      ST_NW: nw  <= prod[NW_W-1:0];
      ST_W1: acc <= prod[ACC_W-1:0];
      ST_W2: acc <= acc + prod[ACC_W-1:0];
      ST_W3: acc <= acc + prod[ACC_W-1:0];
      ST_RS: s1  <= ramp_s_on ? ramp_prod : sine;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample <= s2;
      out_last   <= last_c;
    end
  end

  assign result.valid  = out_valid;
  assign result.sample = out_sample;
  assign result.last   = out_last;

endmodule

`default_nettype wire

// ===== design/gtws_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gtws_checker import gtws_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    item_ready,
  input logic                    result_valid,
  input logic                    result_ready,
  input logic signed [SMP_W-1:0] sample,
  input logic                    last
);

  // a stalled result beat stays up
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its payload
  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(sample) && $stable(last))
    else $error("result payload changed while stalled");

  // samples are clipped to a symmetric range
  a_sample_clip: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> sample != {1'b1, {(SMP_W-1){1'b0}}})
    else $error("sample hit the negative full-scale code");

  // a new sample is only produced by a tick in flight, never out of idle
  a_sample_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(!item_ready))
    else $error("sample appeared without a tick in progress");

endmodule

bind gfsk_tone_waveform_synth gtws_checker u_gtws_checker (
  .clk          (clk),
  .rst          (rst),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .sample       (result.sample),
  .last         (result.last)
);

`default_nettype wire
